// File: rtl/xlb_pkg.sv
// Shared types and constants for the XOR linear basis core.
package xlb_pkg;

  // Vector width and pivot index width
  localparam int unsigned VEC_BITS = 63;
  localparam int unsigned IDX_W    = $clog2(VEC_BITS);

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0]          cmd;
    logic [VEC_BITS-1:0] vector_value;
  } item_t;

  // Result word
  typedef struct packed {
    logic [VEC_BITS-1:0] max_xor;
    logic                was_independent;
  } result_t;

  // Word travelling down the cell chain
  typedef struct packed {
    logic                valid;
    logic [1:0]          cmd;
    logic [VEC_BITS-1:0] v;
    logic                found;
    logic [IDX_W-1:0]    pivot;
  } flow_t;

  // Row update broadcast at the end of a pass
  typedef struct packed {
    logic                upd;
    logic                clr;
    logic [IDX_W-1:0]    pivot;
    logic [VEC_BITS-1:0] v;
  } commit_t;

endpackage

// File: rtl/xlb_cell.sv
// One basis cell: holds the row for a single pivot bit and reduces the passing word.
module xlb_cell
  import xlb_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  flow_t   flow_in,
  input  commit_t commit,
  output flow_t   flow_out
);

  logic [VEC_BITS-1:0] row;
  flow_t               flow_next;
  logic                row_nz;
  logic                vbit;

  assign row_nz = |row;
  assign vbit   = flow_in.v[POS];

  // Reduce the word against this row
  always_comb begin
    flow_next = flow_in;
    case (flow_in.cmd)
      CMD_INSERT: begin
        if (vbit && row_nz) begin
          flow_next.v = flow_in.v ^ row;
        end else if (vbit && !flow_in.found) begin
          flow_next.found = 1'b1;
          flow_next.pivot = IDX_W'(POS);
        end
      end
      CMD_QUERY: begin
        // Taking the row raises the value exactly when its pivot bit is clear
        if (!vbit && row_nz) begin
          flow_next.v = flow_in.v ^ row;
        end
      end
      default: begin
        flow_next = flow_in;
      end
    endcase
  end

  // Advance the word to the next cell down
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_out <= '0;
    end else begin
      flow_out <= flow_next;
    end
  end

  // Hold the row; store a new pivot row or eliminate the new pivot bit
  always_ff @(posedge clk) begin
    if (rst || commit.clr) begin
      row <= '0;
    end else if (commit.upd) begin
      if (commit.pivot == IDX_W'(POS)) begin
        row <= commit.v;
      end else if (commit.pivot < IDX_W'(POS) && row[commit.pivot]) begin
        row <= row ^ commit.v;
      end
    end
  end

endmodule

// File: rtl/xor_linear_basis_core.sv
// Top level of the XOR linear basis core: cell chain, control and result register.
//
//  channel | handshake        | payload
//  --------+------------------+-------------------------------------------
//  input   | start / busy     | item   (cmd, vector_value)
//  result  | done (strobe)    | result (max_xor, was_independent)
//
// Each word walks the 63-cell chain from the top pivot down, one cell a cycle,
// then commits its row update; done and the result are registered as it leaves the last cell.
// busy is high from accept until the commit edge, so a new word can be taken
// in the cycle that done is high. Reset empties the basis at once.
// The result strobe lasts one cycle; the receiver cannot stall it.
module xor_linear_basis_core
  import xlb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  flow_t   flow [VEC_BITS:0];
  commit_t commit;
  logic    accept;

  assign accept = start && !busy;

  // Feed the accepted word into the top cell
  always_comb begin
    flow[VEC_BITS].valid = accept;
    flow[VEC_BITS].cmd   = item.cmd;
    flow[VEC_BITS].v     = item.vector_value;
    flow[VEC_BITS].found = 1'b0;
    flow[VEC_BITS].pivot = '0;
  end

  // Chain of basis cells, highest pivot first
  for (genvar k = 0; k < VEC_BITS; k++) begin : g_cell
    xlb_cell #(
      .POS(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .flow_in (flow[k+1]),
      .commit  (commit),
      .flow_out(flow[k])
    );
  end

  // Broadcast the row update when the word leaves the last cell
  always_comb begin
    commit.upd   = flow[0].valid && (flow[0].cmd == CMD_INSERT) && flow[0].found;
    commit.clr   = flow[0].valid && (flow[0].cmd == CMD_CLEAR);
    commit.pivot = flow[0].pivot;
    commit.v     = flow[0].v;
  end

  // Track the word in flight and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (flow[0].valid) begin
        busy <= 1'b0;
      end
      done <= flow[0].valid;
    end
    result.max_xor         <= (flow[0].cmd == CMD_QUERY) ? flow[0].v : '0;
    result.was_independent <= commit.upd;
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the XOR linear basis core.
module tb;
  import xlb_pkg::*;

  localparam logic [1:0]          CMD_UNUSED = 2'd3;
  localparam logic [VEC_BITS-1:0] ALL_ONES   = '1;
  localparam int                  ITEM_GOAL  = 1150;
  localparam int                  CYCLE_CAP  = 600000;
  localparam int                  DRAIN_WAIT = 80;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    done;
  result_t result;

  item_t   pending_words[$];
  result_t answers_due[$];
  logic [VEC_BITS-1:0] span_rows [VEC_BITS] = '{default: '0};
  int      words_taken = 0;
  int      fails       = 0;
  int      cycle       = 0;

  xor_linear_basis_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one word to the local basis copy and return the result it owes
  function automatic result_t apply_word(input item_t w);
    result_t             r;
    logic [VEC_BITS-1:0] v;
    logic [VEC_BITS-1:0] t;
    bit                  placed;
    int                  k;
    int                  i;
    r      = '0;
    v      = w.vector_value;
    placed = 1'b0;
    case (w.cmd)
      CMD_INSERT: begin
        // reduce from the top pivot; a fresh pivot is fully reduced and stored
        for (k = int'(VEC_BITS) - 1; k >= 0 && !placed && v != '0; k--) begin
          if (v[k]) begin
            if (span_rows[k] != '0) begin
              v ^= span_rows[k];
            end else begin
              for (i = 0; i < k; i++)
                if (v[i]) v ^= span_rows[i];
              for (i = k + 1; i < int'(VEC_BITS); i++)
                if (span_rows[i][k]) span_rows[i] ^= v;
              span_rows[k] = v;
              placed = 1'b1;
            end
          end
        end
        r.was_independent = placed;
      end
      CMD_QUERY: begin
        for (k = int'(VEC_BITS) - 1; k >= 0; k--) begin
          t = v ^ span_rows[k];
          if (t > v) v = t;
        end
        r.max_xor = v;
      end
      CMD_CLEAR: begin
        for (k = 0; k < int'(VEC_BITS); k++) span_rows[k] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t make_word(input logic [1:0] c, input logic [VEC_BITS-1:0] v);
    item_t w;
    w.cmd          = c;
    w.vector_value = v;
    return w;
  endfunction

  // Append one word to the pending queue
  task automatic queue_word(input logic [1:0] c, input logic [VEC_BITS-1:0] v);
    pending_words.insert(pending_words.size(), make_word(c, v));
  endtask

  // Random vector of varied density and effective width
  function automatic logic [VEC_BITS-1:0] pick_vector();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(5))
      0:       return {{(VEC_BITS-1){1'b0}}, 1'b1} << $urandom_range(VEC_BITS - 1);
      1:       return ALL_ONES >> $urandom_range(VEC_BITS - 1);
      2, 3:    return raw[VEC_BITS-1:0] >> $urandom_range(VEC_BITS - 1);
      default: return raw[VEC_BITS-1:0];
    endcase
  endfunction

  // Drive words: predict on accept, then advance or hold off at random
  always @(posedge clk) begin : drive
    int idle_pct;
    idle_pct = (words_taken < 390) ? 10 : (words_taken < 780) ? 82 : 0;
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
    end else begin
      if (start && !busy) begin
        answers_due.insert(answers_due.size(), apply_word(item));
        words_taken++;
      end
      if (!start || !busy) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          item  <= pending_words.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each strobed result against the oldest owed answer
  always @(posedge clk) begin : watch
    result_t want;
    cycle++;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got max_xor=%h was_independent=%b",
                 $time, result.max_xor, result.was_independent);
        fails++;
      end else begin
        want = answers_due.pop_front();
        if (result.max_xor !== want.max_xor) begin
          $display("%0t: max_xor mismatch, expected %h, got %h",
                   $time, want.max_xor, result.max_xor);
          fails++;
        end
        if (result.was_independent !== want.was_independent) begin
          $display("%0t: was_independent mismatch, expected %b, got %b",
                   $time, want.was_independent, result.was_independent);
          fails++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle < CYCLE_CAP) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [VEC_BITS-1:0] made[$];
    logic [VEC_BITS-1:0] v;
    logic [1:0]          c;
    int                  useful;
    int                  span_len;
    int                  n;
    int                  sel;
    useful = 0;

    // Directed: empty basis, extremes, dependent inserts, row cleanup, unused code
    queue_word(CMD_CLEAR,  '0);
    queue_word(CMD_QUERY,  '0);
    queue_word(CMD_QUERY,  ALL_ONES);
    queue_word(CMD_INSERT, '0);
    queue_word(CMD_INSERT, ALL_ONES);
    queue_word(CMD_INSERT, ALL_ONES);
    queue_word(CMD_INSERT, 63'd1);
    queue_word(CMD_QUERY,  '0);
    queue_word(CMD_INSERT, 63'd3);
    queue_word(CMD_INSERT, 63'd2);
    queue_word(CMD_INSERT, 63'd1 << 62);
    queue_word(CMD_QUERY,  63'd1 << 62);
    queue_word(CMD_QUERY,  63'd1);
    queue_word(CMD_UNUSED, ALL_ONES);
    queue_word(CMD_UNUSED, '0);
    queue_word(CMD_CLEAR,  ALL_ONES);
    queue_word(CMD_QUERY,  63'd5);
    queue_word(CMD_INSERT, 63'd5);
    queue_word(CMD_INSERT, 63'd4);
    queue_word(CMD_QUERY,  '0);
    queue_word(CMD_INSERT, 63'd1 << 61);
    queue_word(CMD_INSERT, (63'd1 << 62) | (63'd1 << 61) | 63'd4);
    queue_word(CMD_INSERT, 63'd1 << 62);
    queue_word(CMD_QUERY,  63'h1234_5678_9abc_def0);
    useful = pending_words.size() - 2;

    // Random sessions: fill the basis, mostly well-formed, then clear
    while (useful < ITEM_GOAL) begin
      span_len = $urandom_range(8, 160);
      made.delete();
      for (n = 0; n < span_len && useful < ITEM_GOAL; n++) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          c = CMD_INSERT;
          v = pick_vector();
          made.insert(made.size(), v);
        end else if (sel < 60) begin
          // combination of earlier inserts: dependent unless a clear intervened
          c = CMD_INSERT;
          v = '0;
          foreach (made[j]) if ($urandom_range(1)) v ^= made[j];
        end else if (sel < 97) begin
          c = CMD_QUERY;
          v = pick_vector();
        end else begin
          c = CMD_UNUSED;
          v = pick_vector();
        end
        queue_word(c, v);
        if (c != CMD_UNUSED) useful++;
      end
      queue_word(CMD_CLEAR, pick_vector());
      useful++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: all words accepted, all answers in, then watch for strays
    while (pending_words.size() > 0 || start) @(posedge clk);
    while (answers_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
